// ----- sv/weighted_markov_step_select_defines.svh -----
// Assertion macros for the RTL file that carries checks (wmss_dp.sv).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WEIGHTED_MARKOV_STEP_SELECT_DEFINES_SVH
`define WEIGHTED_MARKOV_STEP_SELECT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WMSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WMSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wmss_pkg.sv -----
`timescale 1ns / 1ps

package wmss_pkg;

  // Default configuration.
  localparam int NODE_COUNT_DEF  = 16;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int RAND_BITS_DEF   = 16;

  // Fixed field widths of the channels.
  localparam int REQ_W    = 1;
  localparam int NODE_W   = 4;
  localparam int WEIGHT_W = 8;
  localparam int RAND_W   = 16;
  localparam int STEP_W   = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE   = 1'b0;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 1'b1;

  // Step code reported when no step is active.
  localparam logic signed [STEP_W-1:0] NO_STEP = -5'sd1;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    U_CLR,
    U_IDLE,
    U_DISP,
    U_WR,
    U_ADV,
    U_FIRST,
    U_SUM,
    U_SUM_END,
    U_MUL_LO,
    U_MUL_HI,
    U_ADD_HI,
    U_WALK,
    U_WALK_END,
    U_PICK,
    U_EMPTY,
    U_DONE
  } upc_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_IDLE,
    OP_WRITE,
    OP_ADV,
    OP_FIRST,
    OP_SUM_RD,
    OP_SUM_END,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD_HI,
    OP_WALK_RD,
    OP_WALK_END,
    OP_PICK,
    OP_EMPTY,
    OP_DONE
  } dp_op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_IS_WRITE,
    C_NO_ACTIVE,
    C_COL_MORE,
    C_CLR_MORE,
    C_SUM_ZERO,
    C_OUT_FREE
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    upc_t   jt;
    upc_t   jf;
  } ucode_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_write;
    logic no_active;
    logic col_more;
    logic clr_more;
    logic sum_zero;
    logic out_free;
  } st_t;

endpackage

// ----- sv/wmss_if.sv -----
`timescale 1ns / 1ps

interface wmss_in_if;
  logic                              valid;
  logic                              ready;
  logic [wmss_pkg::REQ_W-1:0]        req_type;
  logic [wmss_pkg::NODE_W-1:0]       src_node;
  logic [wmss_pkg::NODE_W-1:0]       dst_node;
  logic [wmss_pkg::WEIGHT_W-1:0]     edge_weight;
  logic [wmss_pkg::RAND_W-1:0]       rand_fraction;

  modport source (
    output valid, req_type, src_node, dst_node, edge_weight, rand_fraction,
    input  ready
  );
  modport sink (
    input  valid, req_type, src_node, dst_node, edge_weight, rand_fraction,
    output ready
  );
endinterface

interface wmss_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wmss_pkg::STEP_W-1:0] current_step;
  logic signed [wmss_pkg::STEP_W-1:0] prior_step;
  logic                              empty_row;

  modport source (
    output valid, current_step, prior_step, empty_row,
    input  ready
  );
  modport sink (
    input  valid, current_step, prior_step, empty_row,
    output ready
  );
endinterface

// ----- sv/wmss_mem.sv -----
`timescale 1ns / 1ps

module wmss_mem #(
  parameter int NODE_COUNT  = wmss_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = wmss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [2*$clog2(NODE_COUNT)-1:0]   waddr,
  input  logic [WEIGHT_BITS-1:0]            wdata,
  input  logic                              re,
  input  logic [2*$clog2(NODE_COUNT)-1:0]   raddr,
  output logic [WEIGHT_BITS-1:0]            rdata
);

  localparam int IW    = $clog2(NODE_COUNT);
  localparam int DEPTH = NODE_COUNT * (2 ** IW);

  // Row-major weights, address is {row, column}.
  logic [WEIGHT_BITS-1:0] mem_r [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/wmss_seq.sv -----
`timescale 1ns / 1ps

module wmss_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  wmss_pkg::st_t     st,
  output wmss_pkg::dp_op_t  op
);

  wmss_pkg::upc_t   upc_r;
  wmss_pkg::upc_t   upc_nxt;
  wmss_pkg::ucode_t uc;
  logic             take;

  // The microprogram. Each word names a datapath operation, a jump condition
  // and the two successors.
  function automatic wmss_pkg::ucode_t rom(input wmss_pkg::upc_t a);
    wmss_pkg::ucode_t w;
    w = '{wmss_pkg::OP_NOP, wmss_pkg::C_ALWAYS, wmss_pkg::U_IDLE, wmss_pkg::U_IDLE};
    unique case (a)
      wmss_pkg::U_CLR:      w = '{wmss_pkg::OP_CLEAR, wmss_pkg::C_CLR_MORE,
                                  wmss_pkg::U_CLR, wmss_pkg::U_IDLE};
      wmss_pkg::U_IDLE:     w = '{wmss_pkg::OP_IDLE, wmss_pkg::C_IN_VALID,
                                  wmss_pkg::U_DISP, wmss_pkg::U_IDLE};
      wmss_pkg::U_DISP:     w = '{wmss_pkg::OP_NOP, wmss_pkg::C_IS_WRITE,
                                  wmss_pkg::U_WR, wmss_pkg::U_ADV};
      wmss_pkg::U_WR:       w = '{wmss_pkg::OP_WRITE, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_DONE, wmss_pkg::U_DONE};
      wmss_pkg::U_ADV:      w = '{wmss_pkg::OP_ADV, wmss_pkg::C_NO_ACTIVE,
                                  wmss_pkg::U_FIRST, wmss_pkg::U_SUM};
      wmss_pkg::U_FIRST:    w = '{wmss_pkg::OP_FIRST, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_DONE, wmss_pkg::U_DONE};
      wmss_pkg::U_SUM:      w = '{wmss_pkg::OP_SUM_RD, wmss_pkg::C_COL_MORE,
                                  wmss_pkg::U_SUM, wmss_pkg::U_SUM_END};
      wmss_pkg::U_SUM_END:  w = '{wmss_pkg::OP_SUM_END, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_MUL_LO, wmss_pkg::U_MUL_LO};
      wmss_pkg::U_MUL_LO:   w = '{wmss_pkg::OP_MUL_LO, wmss_pkg::C_SUM_ZERO,
                                  wmss_pkg::U_EMPTY, wmss_pkg::U_MUL_HI};
      wmss_pkg::U_MUL_HI:   w = '{wmss_pkg::OP_MUL_HI, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_ADD_HI, wmss_pkg::U_ADD_HI};
      wmss_pkg::U_ADD_HI:   w = '{wmss_pkg::OP_ADD_HI, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_WALK, wmss_pkg::U_WALK};
      wmss_pkg::U_WALK:     w = '{wmss_pkg::OP_WALK_RD, wmss_pkg::C_COL_MORE,
                                  wmss_pkg::U_WALK, wmss_pkg::U_WALK_END};
      wmss_pkg::U_WALK_END: w = '{wmss_pkg::OP_WALK_END, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_PICK, wmss_pkg::U_PICK};
      wmss_pkg::U_PICK:     w = '{wmss_pkg::OP_PICK, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_DONE, wmss_pkg::U_DONE};
      wmss_pkg::U_EMPTY:    w = '{wmss_pkg::OP_EMPTY, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_DONE, wmss_pkg::U_DONE};
      wmss_pkg::U_DONE:     w = '{wmss_pkg::OP_DONE, wmss_pkg::C_OUT_FREE,
                                  wmss_pkg::U_IDLE, wmss_pkg::U_DONE};
      default:              w = '{wmss_pkg::OP_NOP, wmss_pkg::C_ALWAYS,
                                  wmss_pkg::U_IDLE, wmss_pkg::U_IDLE};
    endcase
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= wmss_pkg::U_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    uc = rom(upc_r);
    op = uc.op;
    unique case (uc.cond)
      wmss_pkg::C_ALWAYS:    take = 1'b1;
      wmss_pkg::C_IN_VALID:  take = st.in_valid;
      wmss_pkg::C_IS_WRITE:  take = st.is_write;
      wmss_pkg::C_NO_ACTIVE: take = st.no_active;
      wmss_pkg::C_COL_MORE:  take = st.col_more;
      wmss_pkg::C_CLR_MORE:  take = st.clr_more;
      wmss_pkg::C_SUM_ZERO:  take = st.sum_zero;
      wmss_pkg::C_OUT_FREE:  take = st.out_free;
      default:               take = 1'b1;
    endcase
    upc_nxt = take ? uc.jt : uc.jf;
  end

endmodule

// ----- sv/wmss_dp.sv -----
`timescale 1ns / 1ps
`include "weighted_markov_step_select_defines.svh"

module wmss_dp #(
  parameter int NODE_COUNT  = wmss_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = wmss_pkg::WEIGHT_BITS_DEF,
  parameter int RAND_BITS   = wmss_pkg::RAND_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wmss_pkg::dp_op_t                       op,
  output wmss_pkg::st_t                          st,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [wmss_pkg::REQ_W-1:0]             in_req_type,
  input  logic [wmss_pkg::NODE_W-1:0]            in_src_node,
  input  logic [wmss_pkg::NODE_W-1:0]            in_dst_node,
  input  logic [wmss_pkg::WEIGHT_W-1:0]          in_edge_weight,
  input  logic [wmss_pkg::RAND_W-1:0]            in_rand_fraction,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [wmss_pkg::STEP_W-1:0]     out_current_step,
  output logic signed [wmss_pkg::STEP_W-1:0]     out_prior_step,
  output logic                                   out_empty_row,
  output logic                                   mem_we,
  output logic [2*$clog2(NODE_COUNT)-1:0]        mem_waddr,
  output logic [WEIGHT_BITS-1:0]                 mem_wdata,
  output logic                                   mem_re,
  output logic [2*$clog2(NODE_COUNT)-1:0]        mem_raddr,
  input  logic [WEIGHT_BITS-1:0]                 mem_rdata
);

  localparam int IW     = $clog2(NODE_COUNT);
  localparam int SUM_W  = WEIGHT_BITS + IW;
  localparam int HALF   = (RAND_BITS + 1) / 2;
  localparam int PP_W   = HALF + SUM_W;
  localparam int PROD_W = RAND_BITS + SUM_W;
  localparam logic [IW-1:0] LAST = IW'(NODE_COUNT - 1);

  // Latched item.
  logic [wmss_pkg::REQ_W-1:0]  req_r;
  logic [wmss_pkg::NODE_W-1:0] src_r;
  logic [wmss_pkg::NODE_W-1:0] dst_r;
  logic [WEIGHT_BITS-1:0]      w_r;
  logic [RAND_BITS-1:0]        r_r;

  // Walk and arithmetic state.
  logic [IW-1:0]     row_r;
  logic [IW-1:0]     col_r;
  logic [IW-1:0]     rcol_r;
  logic              rv_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PP_W-1:0]   pp_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  cum_r;
  logic [IW-1:0]     pick_r;
  logic              found_r;

  // Chain state.
  logic          act_v_r;
  logic [IW-1:0] act_idx_r;
  logic          prev_v_r;
  logic [IW-1:0] prev_idx_r;
  logic          empty_r;

  // Output register.
  logic                              out_valid_r;
  logic signed [wmss_pkg::STEP_W-1:0] out_cur_r;
  logic signed [wmss_pkg::STEP_W-1:0] out_prior_r;
  logic                              out_empty_r;

  logic              accept;
  logic              col_last;
  logic              row_last;
  logic              in_range;
  logic [31:0]       w_ext;
  logic [31:0]       r_ext;
  logic [31:0]       src_ext;
  logic [31:0]       dst_ext;
  logic [RAND_BITS-1:0] r_sh;
  logic [HALF-1:0]   mul_a;
  logic [PP_W-1:0]   mul_p;
  logic [PROD_W-1:0] prod_add;
  logic [SUM_W-1:0]  thr;
  logic [SUM_W-1:0]  cum_add;
  logic [SUM_W-1:0]  sum_add;
  logic              hit;

  function automatic logic [wmss_pkg::STEP_W-1:0] step_code(input logic v,
                                                          input logic [IW-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return v ? ext[wmss_pkg::STEP_W-1:0] : wmss_pkg::NO_STEP;
  endfunction

  assign in_ready = (op == wmss_pkg::OP_IDLE);
  assign accept   = in_valid && in_ready;
  assign col_last = (col_r == LAST);
  assign row_last = (row_r == LAST);

  assign w_ext    = 32'(in_edge_weight);
  assign r_ext    = 32'(in_rand_fraction);
  assign src_ext  = 32'(src_r);
  assign dst_ext  = 32'(dst_r);
  assign in_range = (src_ext < 32'(NODE_COUNT)) && (dst_ext < 32'(NODE_COUNT));

  // One multiplier, fed with the low or the high half of the random value.
  assign r_sh     = r_r >> HALF;
  assign mul_a    = (op == wmss_pkg::OP_MUL_HI) ? r_sh[HALF-1:0] : r_r[HALF-1:0];
  assign mul_p    = PP_W'(mul_a) * PP_W'(sum_r);
  assign prod_add = prod_r + (PROD_W'(pp_r) << HALF);
  assign thr      = prod_r[PROD_W-1:RAND_BITS];

  assign sum_add  = sum_r + SUM_W'(mem_rdata);
  assign cum_add  = cum_r + SUM_W'(mem_rdata);
  assign hit      = rv_r && !found_r && (cum_add > thr);

  assign mem_we    = (op == wmss_pkg::OP_CLEAR) || ((op == wmss_pkg::OP_WRITE) && in_range);
  assign mem_waddr = (op == wmss_pkg::OP_CLEAR) ? {row_r, col_r}
                                                : {src_ext[IW-1:0], dst_ext[IW-1:0]};
  assign mem_wdata = (op == wmss_pkg::OP_CLEAR) ? '0 : w_r;
  assign mem_re    = (op == wmss_pkg::OP_SUM_RD) || (op == wmss_pkg::OP_WALK_RD);
  assign mem_raddr = {row_r, col_r};

  always_comb begin
    st.in_valid  = in_valid;
    st.is_write  = (req_r == wmss_pkg::REQ_WRITE);
    st.no_active = !act_v_r;
    st.col_more  = !col_last;
    st.clr_more  = !(row_last && col_last);
    st.sum_zero  = (sum_r == '0);
    st.out_free  = !out_valid_r || out_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      rv_r        <= 1'b0;
      act_v_r     <= 1'b0;
      prev_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= mem_re;
      unique case (op) inside
        wmss_pkg::OP_CLEAR: begin
          if (col_last) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        wmss_pkg::OP_ADV: begin
          prev_v_r <= act_v_r;
          row_r    <= act_idx_r;
          col_r    <= '0;
        end
        wmss_pkg::OP_FIRST: act_v_r <= 1'b1;
        wmss_pkg::OP_SUM_RD, wmss_pkg::OP_WALK_RD: col_r <= col_r + 1'b1;
        wmss_pkg::OP_ADD_HI: col_r <= '0;
        default: ;
      endcase
      if ((op == wmss_pkg::OP_DONE) && st.out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    rcol_r <= col_r;
    unique case (op) inside
      wmss_pkg::OP_IDLE: begin
        if (accept) begin
          req_r   <= in_req_type;
          src_r   <= in_src_node;
          dst_r   <= in_dst_node;
          w_r     <= w_ext[WEIGHT_BITS-1:0];
          r_r     <= r_ext[RAND_BITS-1:0];
          empty_r <= 1'b0;
        end
      end
      wmss_pkg::OP_ADV: begin
        prev_idx_r <= act_idx_r;
        sum_r      <= '0;
      end
      wmss_pkg::OP_FIRST: act_idx_r <= '0;
      wmss_pkg::OP_SUM_RD, wmss_pkg::OP_SUM_END: begin
        if (rv_r) begin
          sum_r <= sum_add;
        end
      end
      wmss_pkg::OP_MUL_LO: pp_r <= mul_p;
      wmss_pkg::OP_MUL_HI: begin
        pp_r   <= mul_p;
        prod_r <= PROD_W'(pp_r);
      end
      wmss_pkg::OP_ADD_HI: begin
        prod_r  <= prod_add;
        cum_r   <= '0;
        found_r <= 1'b0;
        pick_r  <= '0;
      end
      wmss_pkg::OP_WALK_RD, wmss_pkg::OP_WALK_END: begin
        if (rv_r) begin
          cum_r <= cum_add;
        end
        if (hit) begin
          found_r <= 1'b1;
          pick_r  <= rcol_r;
        end
      end
      wmss_pkg::OP_PICK: act_idx_r <= pick_r;
      wmss_pkg::OP_EMPTY: begin
        act_idx_r <= '0;
        empty_r   <= 1'b1;
      end
      wmss_pkg::OP_DONE: begin
        if (st.out_free) begin
          out_cur_r   <= step_code(act_v_r, act_idx_r);
          out_prior_r <= step_code(prev_v_r, prev_idx_r);
          out_empty_r <= empty_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_current_step = out_cur_r;
  assign out_prior_step   = out_prior_r;
  assign out_empty_row    = out_empty_r;

  `WMSS_ASSERT_NOW(a_thr_below_sum, op == wmss_pkg::OP_WALK_RD, thr < sum_r, "threshold not below row sum")
  `WMSS_ASSERT_NOW(a_pick_found, op == wmss_pkg::OP_PICK, found_r, "row walk found no column")
  `WMSS_ASSERT_NOW(a_walk_total, op == wmss_pkg::OP_PICK, cum_r == sum_r, "walk total differs from row sum")
  `WMSS_ASSERT_NOW(a_empty_zero, op == wmss_pkg::OP_EMPTY, sum_r == '0, "empty fallback on nonzero row")

endmodule

// ----- sv/weighted_markov_step_select.sv -----
// Items are taken one at a time: the next only once the last result is in the output
// register. A write item stores its weight when both nodes are in range. An advance
// item makes two passes over the row through one memory read port, a sum and a walk;
// an empty row skips the walk. The first advance after reset makes neither pass. A
// synchronous reset clears the steps, then zeroes the memory with ready low.
`timescale 1ns / 1ps

module weighted_markov_step_select #(
  parameter int NODE_COUNT  = wmss_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = wmss_pkg::WEIGHT_BITS_DEF,
  parameter int RAND_BITS   = wmss_pkg::RAND_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  wmss_in_if.sink    in_ch,
  wmss_out_if.source out_ch
);

  localparam int AW = 2 * $clog2(NODE_COUNT);

  // The sequencer steps through a small microprogram; each control word
  // selects one datapath operation and a conditional jump. The datapath
  // holds the item, the chain state, the row sum, the scaled threshold and
  // the running total of the walk, plus the output register that lets a
  // finished result wait while the block goes back to idle.
  wmss_pkg::dp_op_t op;
  wmss_pkg::st_t    st;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [WEIGHT_BITS-1:0] mem_rdata;

  wmss_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .op    (op)
  );

  // The transition weights live in a single-port-read, single-port-write
  // memory addressed by row and column. Its read data is registered, so the
  // summing and the walking passes each end with a drain step for the last read.
  wmss_mem #(
    .NODE_COUNT  (NODE_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The threshold is floor(r * sum / 2^RAND_BITS), built from two half-width
  // partial products so that no multiplier is wider than the row sum by half
  // of the random value. The walk then picks the first column whose running
  // total exceeds it; an empty row falls back to step 0 and flags it.
  wmss_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RAND_BITS   (RAND_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .st               (st),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_req_type      (in_ch.req_type),
    .in_src_node      (in_ch.src_node),
    .in_dst_node      (in_ch.dst_node),
    .in_edge_weight   (in_ch.edge_weight),
    .in_rand_fraction (in_ch.rand_fraction),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_current_step (out_ch.current_step),
    .out_prior_step   (out_ch.prior_step),
    .out_empty_row    (out_ch.empty_row),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

endmodule
